// ----- sv/bpa_pkg.sv -----
// shared types, register codes and constant tables of the beam potential accumulator
// no dependencies
package bpa_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_BAND  = 2'd0;
	localparam logic [1:0] CFG_BASE  = 2'd1;
	localparam logic [1:0] CFG_BOUND = 2'd2;

	typedef struct packed {
		logic        band;
		logic [14:0] base_freq_mhz;
		logic [15:0] adc_bound;
	} cfg_t;

	// one finished point handed from front to back
	typedef struct packed {
		logic [2:0]  beam;
		logic [7:0]  freq_index;
		logic [27:0] sum_power;
		logic        calibrated;
	} point_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FREQ,
		ST_SEG,
		ST_NUM1,
		ST_NUM2,
		ST_CLAMP,
		ST_DIV,
		ST_DIGW,
		ST_DIGT,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_RND,
		ST_OUT
	} back_state_t;

	// 10^(d/10) for whole dB, q16
	localparam logic [22:0] DB_WHOLE_Q16 [19] = '{
		23'd65536, 23'd82505, 23'd103868, 23'd130762, 23'd164619, 23'd207243,
		23'd260904, 23'd328458, 23'd413504, 23'd520571, 23'd655360, 23'd825049,
		23'd1038676, 23'd1307615, 23'd1646190, 23'd2072430, 23'd2609035,
		23'd3284581, 23'd4135042
	};
	// 10^(t/100) for tenths of a dB, q24
	localparam logic [24:0] DB_TENTH_Q24 [10] = '{
		25'd16777216, 25'd17168008, 25'd17567902, 25'd17977111, 25'd18395852,
		25'd18824346, 25'd19262821, 25'd19711510, 25'd20170650, 25'd20640485
	};
	// 10^(h/1000) for hundredths of a dB, q24
	localparam logic [24:0] DB_HUND_Q24 [10] = '{
		25'd16777216, 25'd16815891, 25'd16854656, 25'd16893510, 25'd16932454,
		25'd16971487, 25'd17010610, 25'd17049824, 25'd17089128, 25'd17128522
	};

	// beam correction end points in centi-dB, low band, index {segment, beam}
	localparam logic signed [9:0] CORR_LOW_C1 [16] = '{
		-10'sd200, -10'sd100, 10'sd0, -10'sd250,
		10'sd50, 10'sd150, 10'sd0, 10'sd100,
		-10'sd50, 10'sd100, 10'sd0, 10'sd0,
		-10'sd70, 10'sd50, 10'sd0, -10'sd50
	};
	localparam logic signed [9:0] CORR_LOW_C2 [16] = '{
		10'sd50, 10'sd150, 10'sd0, 10'sd100,
		-10'sd50, 10'sd100, 10'sd0, 10'sd0,
		-10'sd70, 10'sd50, 10'sd0, -10'sd50,
		-10'sd150, 10'sd0, 10'sd0, 10'sd0
	};
	// high band, index {segment, beam}, segments 0..4
	localparam logic signed [9:0] CORR_HIGH_C1 [40] = '{
		-10'sd50, -10'sd20, 10'sd50, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0,
		-10'sd300, -10'sd100, 10'sd50, 10'sd0, 10'sd10, 10'sd0, -10'sd100, -10'sd300,
		-10'sd220, -10'sd50, 10'sd20, 10'sd0, 10'sd0, 10'sd0, 10'sd0, -10'sd150,
		-10'sd250, -10'sd50, -10'sd10, 10'sd0, 10'sd0, 10'sd0, -10'sd10, -10'sd210,
		-10'sd300, -10'sd200, 10'sd0, 10'sd0, -10'sd20, -10'sd10, -10'sd220, -10'sd220
	};
	localparam logic signed [9:0] CORR_HIGH_C2 [40] = '{
		-10'sd300, -10'sd100, 10'sd50, 10'sd0, 10'sd10, 10'sd0, -10'sd100, -10'sd300,
		-10'sd220, -10'sd50, 10'sd20, 10'sd0, 10'sd0, 10'sd0, 10'sd0, -10'sd150,
		-10'sd250, -10'sd50, -10'sd10, 10'sd0, 10'sd0, 10'sd0, -10'sd10, -10'sd210,
		-10'sd300, -10'sd200, 10'sd0, 10'sd0, -10'sd20, -10'sd10, -10'sd220, -10'sd220,
		-10'sd250, -10'sd20, 10'sd20, 10'sd0, 10'sd0, -10'sd10, -10'sd10, -10'sd220
	};

endpackage

// ----- sv/bpa_ifs.sv -----
// valid/ready channel interfaces for measurements in and point results out
// no dependencies
interface bpa_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  beam;
	logic [7:0]  freq_index;
	logic [23:0] power;
	logic [15:0] adc_code;
	logic        last_output;

	modport source (output valid, beam, freq_index, power, adc_code, last_output,
		input ready);
	modport sink (input valid, beam, freq_index, power, adc_code, last_output,
		output ready);
endinterface

interface bpa_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_beam;
	logic [7:0]  out_freq_index;
	logic [27:0] sum_power;
	logic [33:0] potential;
	logic        calibrated;
	logic        out_of_range;

	modport source (output valid, out_beam, out_freq_index, sum_power, potential,
		calibrated, out_of_range, input ready);
	modport sink (input valid, out_beam, out_freq_index, sum_power, potential,
		calibrated, out_of_range, output ready);
endinterface

// ----- sv/bpa_front.sv -----
// front end: accepts measurement beats, sums power and tracks calibration per point
// depends on bpa_pkg and bpa_in_if
module bpa_front import bpa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	bpa_in_if.sink  meas,
	input  logic    full,
	output logic    push,
	output point_t  push_data
);

	logic [27:0] sum_q;
	logic        cal_q;
	logic [28:0] sum_ext;
	logic [27:0] sum_nxt;
	logic        cal_nxt;
	logic        accept;

	assign meas.ready = !full;
	assign accept = meas.valid && meas.ready;

	always_comb begin
		sum_ext = {1'b0, sum_q} + {5'd0, meas.power};
		sum_nxt = sum_ext[28] ? '1 : sum_ext[27:0];
		cal_nxt = cal_q && (meas.adc_code >= cfg.adc_bound);
	end

	assign push = accept && meas.last_output;
	assign push_data = '{beam: meas.beam, freq_index: meas.freq_index,
		sum_power: sum_nxt, calibrated: cal_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cal_q <= 1'b1;
		end else if (accept) begin
			if (meas.last_output) begin
				sum_q <= '0;
				cal_q <= 1'b1;
			end else begin
				sum_q <= sum_nxt;
				cal_q <= cal_nxt;
			end
		end
	end

endmodule

// ----- sv/bpa_queue.sv -----
// small point queue between front and back
// depends on bpa_pkg
module bpa_queue import bpa_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  point_t push_data,
	input  logic   pop,
	output point_t pop_data,
	output logic   full,
	output logic   empty
);

	// depth 2 or more
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	point_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/bpa_back.sv -----
// back end: frequency, gain curve, db to linear factor and potential for one point
// depends on bpa_pkg and bpa_out_if
module bpa_back import bpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     empty,
	input  point_t   pop_data,
	output logic     pop,
	bpa_out_if.source result
);

	// common denominators of the two interpolations, per band
	localparam logic [12:0] L_LO = 13'd6000;
	localparam logic [12:0] L_HI = 13'd4000;
	localparam logic [26:0] LIM_LO = 27'd10806000;
	localparam logic [26:0] LIM_HI = 27'd7204000;
	localparam logic [10:0] CDB_MAX = 11'd1800;
	// ceil(2^37 / denominator), exact floor quotient below the clamp limit
	localparam logic [25:0] RECIP_LO = 26'd22906493;
	localparam logic [25:0] RECIP_HI = 26'd34359739;

	back_state_t state_q, state_nxt;

	point_t              pt_q;
	logic [15:0]         f_q;
	logic                oor_q;
	logic signed [11:0]  yc_q;
	logic signed [9:0]   a_q, b_q;
	logic [12:0]         dxf_q, dcf_q;
	logic [3:0]          m1_q;
	logic signed [25:0]  p0_q;
	logic signed [23:0]  p1_q, p2_q;
	logic signed [27:0]  num_q;
	logic [23:0]         rem_q;
	logic [10:0]         quo_q;
	logic [4:0]          w_q;
	logic [3:0]          t_q;
	logic [23:0]         fac_q;
	logic [51:0]         prod_q;
	logic [33:0]         pot_q;

	logic [12:0]         l_cur;
	logic [2:0]          m2_cur;
	logic [26:0]         lim_cur;
	logic [25:0]         recip_cur;

	// segment selection
	logic                s_oor;
	logic [15:0]         x1, cx1;
	logic signed [11:0]  y1;
	logic signed [9:0]   s_a;
	logic [3:0]          s_m1;
	logic [2:0]          cs;
	logic signed [9:0]   c1, c2;

	logic [47:0]         prod1;
	logic [48:0]         prod2;
	logic [52:0]         rnd;
	logic [49:0]         quo_prod;

	always_comb begin
		l_cur     = cfg.band ? L_HI : L_LO;
		m2_cur    = cfg.band ? 3'd2 : 3'd6;
		lim_cur   = cfg.band ? LIM_HI : LIM_LO;
		recip_cur = cfg.band ? RECIP_HI : RECIP_LO;
	end

	always_comb begin
		x1 = 16'd4000;
		y1 = 12'sd870;
		s_a = 10'sd300;
		s_m1 = 4'd3;
		cs = 3'd0;
		cx1 = 16'd4000;
		c1 = '0;
		c2 = '0;
		if (!cfg.band) begin
			s_oor = pt_q.beam[2] || (f_q < 16'd4000) || (f_q > 16'd8000);
			if (f_q <= 16'd6000) begin
				x1 = 16'd4000; y1 = 12'sd870; s_a = 10'sd300; s_m1 = 4'd3;
			end else if (f_q <= 16'd6500) begin
				x1 = 16'd6000; y1 = 12'sd1170; s_a = 10'sd160; s_m1 = 4'd12;
			end else begin
				x1 = 16'd6500; y1 = 12'sd1330; s_a = 10'sd140; s_m1 = 4'd4;
			end
			if (f_q <= 16'd5000) begin
				cs = 3'd0; cx1 = 16'd4000;
			end else if (f_q <= 16'd6000) begin
				cs = 3'd1; cx1 = 16'd5000;
			end else if (f_q <= 16'd7000) begin
				cs = 3'd2; cx1 = 16'd6000;
			end else begin
				cs = 3'd3; cx1 = 16'd7000;
			end
			c1 = CORR_LOW_C1[{cs[1:0], pt_q.beam[1:0]}];
			c2 = CORR_LOW_C2[{cs[1:0], pt_q.beam[1:0]}];
		end else begin
			// 8 GHz itself belongs to the first segment
			s_oor = (f_q < 16'd8000) || (f_q > 16'd18000);
			if (f_q <= 16'd12000) begin
				x1 = 16'd8000; y1 = 12'sd1140; s_a = 10'sd300; s_m1 = 4'd1;
			end else if (f_q <= 16'd13000) begin
				x1 = 16'd12000; y1 = 12'sd1440; s_a = -10'sd70; s_m1 = 4'd4;
			end else begin
				x1 = 16'd13000; y1 = 12'sd1370; s_a = -10'sd10; s_m1 = 4'd1;
			end
			if (f_q <= 16'd10000) begin
				cs = 3'd0; cx1 = 16'd8000;
			end else if (f_q <= 16'd12000) begin
				cs = 3'd1; cx1 = 16'd10000;
			end else if (f_q <= 16'd14000) begin
				cs = 3'd2; cx1 = 16'd12000;
			end else if (f_q <= 16'd16000) begin
				cs = 3'd3; cx1 = 16'd14000;
			end else begin
				cs = 3'd4; cx1 = 16'd16000;
			end
			c1 = CORR_HIGH_C1[{cs, pt_q.beam}];
			c2 = CORR_HIGH_C2[{cs, pt_q.beam}];
		end
	end

	always_comb begin
		prod1 = 48'(DB_WHOLE_Q16[w_q]) * 48'(DB_TENTH_Q24[t_q]) + 48'h800000;
		prod2 = 49'(fac_q) * 49'(DB_HUND_Q24[quo_q[3:0]]) + 49'h800000;
		rnd   = {1'b0, prod_q} + 53'h8000;
		quo_prod = 50'(rem_q) * 50'(recip_cur);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (!empty) state_nxt = ST_FREQ;
			ST_FREQ:  state_nxt = ST_SEG;
			ST_SEG:   state_nxt = s_oor ? ST_OUT : ST_NUM1;
			ST_NUM1:  state_nxt = ST_NUM2;
			ST_NUM2:  state_nxt = ST_CLAMP;
			ST_CLAMP: begin
				if (num_q[27] || (num_q[26:0] >= lim_cur)) state_nxt = ST_DIGW;
				else state_nxt = ST_DIV;
			end
			ST_DIV:   state_nxt = ST_DIGW;
			ST_DIGW:  if (quo_q < 11'd100) state_nxt = ST_DIGT;
			ST_DIGT:  if (quo_q < 11'd10) state_nxt = ST_MUL1;
			ST_MUL1:  state_nxt = ST_MUL2;
			ST_MUL2:  state_nxt = ST_MUL3;
			ST_MUL3:  state_nxt = ST_RND;
			ST_RND:   state_nxt = ST_OUT;
			ST_OUT:   if (result.ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop = (state_q == ST_IDLE) && !empty;
		result.valid = (state_q == ST_OUT);
		result.out_beam = pt_q.beam;
		result.out_freq_index = pt_q.freq_index;
		result.sum_power = pt_q.sum_power;
		result.potential = pot_q;
		result.calibrated = pt_q.calibrated;
		result.out_of_range = oor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) pt_q <= pop_data;
			end
			ST_FREQ: begin
				f_q <= 16'(pt_q.freq_index[7:3]) * 16'd500
					+ {7'd0, pt_q.freq_index[2:0], 6'd0}
					+ {1'b0, cfg.base_freq_mhz} + 16'd26;
			end
			ST_SEG: begin
				oor_q <= s_oor;
				pot_q <= '0;
				yc_q  <= y1 + 12'(c1);
				a_q   <= s_a;
				b_q   <= c2 - c1;
				m1_q  <= s_m1;
				dxf_q <= 13'(f_q - x1);
				dcf_q <= 13'(f_q - cx1);
			end
			ST_NUM1: begin
				p0_q <= yc_q * $signed({1'b0, l_cur});
				p1_q <= a_q * $signed({1'b0, dxf_q});
				p2_q <= b_q * $signed({1'b0, dcf_q});
			end
			ST_NUM2: begin
				// half the denominator added so the floor rounds half up
				num_q <= 28'(p0_q) + 28'(p1_q) * $signed({1'b0, m1_q})
					+ 28'(p2_q) * $signed({1'b0, m2_cur})
					+ $signed({16'd0, l_cur[12:1]});
			end
			ST_CLAMP: begin
				w_q <= '0;
				t_q <= '0;
				rem_q <= num_q[23:0];
				if (num_q[27]) quo_q <= '0;
				else if (num_q[26:0] >= lim_cur) quo_q <= CDB_MAX;
				else quo_q <= '0;
			end
			ST_DIV:  quo_q <= quo_prod[47:37];
			ST_DIGW: begin
				if (quo_q >= 11'd100) begin
					quo_q <= quo_q - 11'd100;
					w_q <= w_q + 1'b1;
				end
			end
			ST_DIGT: begin
				if (quo_q >= 11'd10) begin
					quo_q <= quo_q - 11'd10;
					t_q <= t_q + 1'b1;
				end
			end
			ST_MUL1: fac_q <= prod1[47:24];
			ST_MUL2: fac_q <= prod2[47:24];
			ST_MUL3: prod_q <= 52'(pt_q.sum_power) * 52'(fac_q);
			ST_RND:  pot_q <= (|rnd[52:50]) ? '1 : rnd[49:16];
			default: ;
		endcase
	end

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> (quo_q <= CDB_MAX))
		else $error("gain quotient above clamp");
	a_whole_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1) |-> (w_q <= 5'd18 && t_q <= 4'd9 && quo_q <= 11'd9))
		else $error("db digit out of table range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!empty && state_q == ST_IDLE))
		else $error("pop from empty point queue");

endmodule

// ----- sv/beam_potential_accumulator.sv -----
// top level of the beam potential accumulator: config registers, front, queue, back
// depends on bpa_pkg, bpa_ifs, bpa_front, bpa_queue and bpa_back
//
// Measurement beats are summed per (beam, frequency) point at one beat per clock;
// the beat with last_output set closes the point and one result beat follows.
// The front never stalls while the point queue (QUEUE_DEPTH points) has room.
// The back works on one point at a time: an out-of-range point goes through take,
// frequency, segment and result only; any other point also goes through the
// reciprocal multiply for the gain quotient (skipped when the gain is clamped), the
// split of the gain into dB digits by repeated subtraction (up to 28 steps), three
// registered multiplies and a rounding step. So a stream sustains one beat per cycle
// when points hold enough beats to cover the back's work; shorter points run at its pace.
// Configuration writes take effect at once and should happen with no point open.
module beam_potential_accumulator import bpa_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	bpa_in_if.sink      meas,
	bpa_out_if.source   result
);

	cfg_t   cfg_q;
	logic   push, pop, full, empty;
	point_t push_data, pop_data;

	// register file, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band <= 1'b0;
			cfg_q.base_freq_mhz <= 15'd4000;
			cfg_q.adc_bound <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BAND:  cfg_q.band <= cfg_data[0];
				CFG_BASE:  cfg_q.base_freq_mhz <= cfg_data[14:0];
				CFG_BOUND: cfg_q.adc_bound <= cfg_data;
				default: ;
			endcase
		end
	end

	// accumulation of measurement beats
	bpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.meas      (meas),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// finished points waiting for the gain pipeline
	bpa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	// gain and potential, result held until taken
	bpa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.empty    (empty),
		.pop_data (pop_data),
		.pop      (pop),
		.result   (result)
	);

endmodule
